// ===== sv/sha1md_pkg.sv =====
// Shared types and constants for the SHA-1 message digest unit.
package sha1md_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 61;
    localparam int unsigned IDX_W  = 3;

    // Initial chaining value, H0 in element 0.
    localparam logic [4:0][WORD_W-1:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [WORD_W-1:0] K_ROUND0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_ROUND3 = 32'hCA62C1D6;

    localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

    // One classified request on its way from the front end to the engine.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              end_of_message;
    } cmd_t;

endpackage

// ===== sv/sha1md_fifo.sv =====
// Small register queue that carries requests from the front end to the engine.
module sha1md_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sha1md_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output sha1md_pkg::cmd_t pop_cmd
);
    import sha1md_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request written into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("request taken from an empty queue");

    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!push && !pop) |=> $stable(count_reg))
        else $error("queue fill level moved without a push or pop");

endmodule

// ===== sv/sha1md_front.sv =====
// Input front end: accepts stream requests, drops empty ones, queues the rest.
module sha1md_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sha1md_pkg::BYTE_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic                          s_tuser,  // [0] has_byte
    input  logic                          s_tlast,  // end_of_message
    input  logic                          full,
    output logic                          push,
    output sha1md_pkg::cmd_t              push_cmd
);
    import sha1md_pkg::*;

    assign s_tready = !full;

    // A request carrying neither a byte nor an end mark has no effect, so it
    // never takes a queue slot.
    assign push = s_tvalid && s_tready && (s_tuser || s_tlast);

    always_comb
    begin
        push_cmd.data_byte      = s_tdata;
        push_cmd.has_byte       = s_tuser;
        push_cmd.end_of_message = s_tlast;
    end

endmodule

// ===== sv/sha1md_core.sv =====
// SHA-1 engine: block assembly, padding, 80-round compression and digest output.
module sha1md_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  sha1md_pkg::cmd_t              q_cmd,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sha1md_pkg::WORD_W-1:0] m_tdata,
    output logic [sha1md_pkg::IDX_W-1:0]  m_tuser,
    output logic                          m_tlast
);
    import sha1md_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_LEN,
        S_COMP,
        S_ADD,
        S_OUT
    } state_t;

    state_t                   state_reg, state_next;
    state_t                   ret_reg, ret_next;
    logic [5:0]               fill_reg, fill_next;
    logic [LEN_W-1:0]         msg_reg, msg_next;
    logic [23:0]              acc_reg, acc_next;
    logic [15:0][WORD_W-1:0]  w_reg, w_next;
    logic [4:0][WORD_W-1:0]   var_reg, var_next;
    logic [4:0][WORD_W-1:0]   chain_reg, chain_next;
    logic [6:0]               round_reg, round_next;
    logic [63:0]              len_reg, len_next;
    logic [2:0]               len_cnt_reg, len_cnt_next;
    logic [IDX_W-1:0]         out_cnt_reg, out_cnt_next;
    logic                     m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]        m_data_reg, m_data_next;
    logic [IDX_W-1:0]         m_idx_reg, m_idx_next;
    logic                     m_last_reg, m_last_next;

    logic                     push_en;
    logic [BYTE_W-1:0]        push_byte;
    logic [WORD_W-1:0]        f_val;
    logic [WORD_W-1:0]        k_val;
    logic [WORD_W-1:0]        t_val;
    logic [WORD_W-1:0]        sched;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_idx_reg;
    assign m_tlast  = m_last_reg;

    // Round function and constant, chosen by the round number.
    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (var_reg[1] & var_reg[2]) | (~var_reg[1] & var_reg[3]);
            k_val = K_ROUND0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
            k_val = K_ROUND1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (var_reg[1] & var_reg[2]) | (var_reg[1] & var_reg[3])
                  | (var_reg[2] & var_reg[3]);
            k_val = K_ROUND2;
        end
        else
        begin
            f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
            k_val = K_ROUND3;
        end
    end

    assign t_val = {var_reg[0][26:0], var_reg[0][31:27]} + f_val + var_reg[4]
                 + k_val + w_reg[0];
    assign sched = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        fill_next    = fill_reg;
        msg_next     = msg_reg;
        acc_next     = acc_reg;
        w_next       = w_reg;
        var_next     = var_reg;
        chain_next   = chain_reg;
        round_next   = round_reg;
        len_next     = len_reg;
        len_cnt_next = len_cnt_reg;
        out_cnt_next = out_cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_idx_next   = m_idx_reg;
        m_last_next  = m_last_reg;
        push_en      = 1'b0;
        push_byte    = '0;
        q_pop        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.has_byte)
                    begin
                        push_en   = 1'b1;
                        push_byte = q_cmd.data_byte;
                        msg_next  = msg_reg + 1'b1;
                    end
                    if (q_cmd.end_of_message)
                    begin
                        state_next = S_PAD80;
                    end
                end
            end
            S_PAD80:
            begin
                push_en      = 1'b1;
                push_byte    = PAD_MARK;
                len_next     = {msg_reg, 3'b000};
                len_cnt_next = '0;
                state_next   = S_PADZ;
            end
            S_PADZ:
            begin
                if (fill_reg == 6'd56)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    push_en = 1'b1;
                end
            end
            S_LEN:
            begin
                push_en      = 1'b1;
                push_byte    = len_reg[63:56];
                len_next     = {len_reg[55:0], 8'h00};
                len_cnt_next = len_cnt_reg + 1'b1;
                state_next   = (len_cnt_reg == 3'd7) ? S_OUT : S_LEN;
            end
            S_COMP:
            begin
                w_next     = {{sched[30:0], sched[31]}, w_reg[15:1]};
                var_next   = {var_reg[3], var_reg[2],
                              {var_reg[1][1:0], var_reg[1][31:2]},
                              var_reg[0], t_val};
                round_next = round_reg + 1'b1;
                if (round_reg == 7'd79)
                begin
                    round_next = '0;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_next[i] = chain_reg[i] + var_reg[i];
                end
                out_cnt_next = '0;
                state_next   = ret_reg;
            end
            S_OUT:
            begin
                // Words leave from element 0 while the chain rotates under it.
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = chain_reg[0];
                    m_idx_next   = out_cnt_reg;
                    m_last_next  = (out_cnt_reg == 3'd4);
                    chain_next   = {chain_reg[0], chain_reg[4:1]};
                    out_cnt_next = out_cnt_reg + 1'b1;
                    if (out_cnt_reg == 3'd4)
                    begin
                        chain_next = H_INIT;
                        msg_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Byte path shared by message bytes and padding bytes.
        if (push_en)
        begin
            acc_next  = {acc_reg[15:0], push_byte};
            fill_next = fill_reg + 1'b1;
            if (fill_reg[1:0] == 2'b11)
            begin
                w_next = {{acc_reg, push_byte}, w_reg[15:1]};
            end
            if (fill_reg == 6'd63)
            begin
                ret_next   = state_next;
                state_next = S_COMP;
                var_next   = chain_reg;
                round_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            fill_reg    <= '0;
            msg_reg     <= '0;
            chain_reg   <= H_INIT;
            round_reg   <= '0;
            len_cnt_reg <= '0;
            out_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            fill_reg    <= fill_next;
            msg_reg     <= msg_next;
            chain_reg   <= chain_next;
            round_reg   <= round_next;
            len_cnt_reg <= len_cnt_next;
            out_cnt_reg <= out_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        w_reg      <= w_next;
        var_reg    <= var_next;
        len_reg    <= len_next;
        m_data_reg <= m_data_next;
        m_idx_reg  <= m_idx_next;
        m_last_reg <= m_last_next;
    end

    a_len_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEN) |-> (fill_reg[5:3] == 3'b111))
        else $error("length bytes placed outside the last eight block bytes");

    a_out_empty_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (fill_reg == '0))
        else $error("digest output with a partly filled block");

    a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP && round_reg == 7'd79) |=> (state_reg == S_ADD))
        else $error("compression did not end after the last round");

endmodule

// ===== sv/sha1_message_digest_unit.sv =====
// Top level of the SHA-1 message digest unit.
//
//  Channel   Direction  Handshake          Contents
//  s_*       in         s_tvalid/s_tready  one message byte, has-byte flag, end mark
//  m_*       out        m_tvalid/m_tready  one digest word, its index, last-word mark
//
// Flow: the engine takes one queued byte per cycle while no block is being
// compressed; every full 64-byte block then occupies the shared round unit for
// 80 rounds and a final step that folds the result into the chaining value.
// Closing a message feeds the padding and the 8 length bytes through the same
// byte path and runs one or two further compressions before the five digest
// words leave, one per cycle while the output is not stalled.
// Reset is asynchronous and active low; it loads the initial chaining value
// and clears all control state, and the unit accepts requests right after.
// While the engine compresses, the request queue keeps accepting bytes until
// it holds QUEUE_DEPTH requests; a stalled output holds its word in the
// output register and the engine waits for that register only.
module sha1_message_digest_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sha1md_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                          s_tuser,   // [0] has_byte
    input  logic                          s_tlast,   // end_of_message
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sha1md_pkg::WORD_W-1:0] m_tdata,   // [31:0] digest_word
    output logic [sha1md_pkg::IDX_W-1:0]  m_tuser,   // [2:0] word_index
    output logic                          m_tlast    // last_word
);
    import sha1md_pkg::*;

    logic full;
    logic empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    // Front end: requests with no byte and no end mark are consumed and dropped.
    sha1md_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Request queue that lets the front end keep taking bytes during rounds.
    sha1md_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .pop_cmd  (pop_cmd)
    );

    // Engine: block assembly, padding, compression and the digest output register.
    sha1md_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (!empty),
        .q_cmd    (pop_cmd),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
